/* rtl/ptt_pkg.sv */
// Shared types and constants of the periodic task timer table.
package ptt_pkg;

    // Default number of task slots
    localparam int MAX_TASKS_DEF = 16;

    // Fixed field widths
    localparam int TIME_W = 32;
    localparam int SLOT_W = 6;

    // Input command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        K_FIRE     = 2'd0,
        K_ADD_OK   = 2'd1,
        K_ADD_FULL = 2'd2,
        K_TICK_END = 2'd3
    } t_kind;

    // Control states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    // One task slot as stored in the table memory
    typedef struct packed {
        logic [TIME_W-1:0] next_ref_time;
        logic [TIME_W-1:0] birth_time;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] pending_offset;
        logic [TIME_W-1:0] calls_done;
        logic [TIME_W-1:0] calls_allowed;
        logic [TIME_W-1:0] life_span;
    } t_entry;

    // Outcome of evaluating one slot during a tick
    typedef struct packed {
        logic              fire;
        logic              done;
        logic [TIME_W-1:0] calls;
        t_entry            entry;
    } t_eval_res;

endpackage

/* rtl/ptt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ptt_eval.sv */
// Due check and update of one task slot against the tick time.
module ptt_eval (
    input  logic                                i_slot_valid,
    input  logic [ptt_pkg::TIME_W-1:0]          i_now,
    input  ptt_pkg::t_entry                     i_entry,
    output ptt_pkg::t_eval_res                  o_res
);
    import ptt_pkg::*;

    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] calls;
    logic              restart;
    logic              due;

    // Elapsed time since reference, wraps mod 2^32
    assign delta   = i_now - i_entry.next_ref_time;
    assign due     = i_slot_valid && (delta >= i_entry.interval)
                     && (delta >= i_entry.pending_offset);
    assign restart = (i_entry.pending_offset != '0);
    assign calls   = i_entry.calls_done + TIME_W'(1);
    // A restart sets birth to now, so the age is then zero
    assign age     = restart ? '0 : (i_now - i_entry.birth_time);

    // Updated slot contents
    always_comb begin
        o_res.fire                 = due;
        o_res.calls                = calls;
        o_res.done                 = ((i_entry.calls_allowed != '0)
                                      && (calls >= i_entry.calls_allowed))
                                     || ((i_entry.life_span != '0)
                                      && (age >= i_entry.life_span));
        o_res.entry                = i_entry;
        o_res.entry.calls_done     = calls;
        o_res.entry.pending_offset = '0;
        if (restart) begin
            o_res.entry.next_ref_time = i_now;
            o_res.entry.birth_time    = i_now;
        end else begin
            o_res.entry.next_ref_time = i_entry.next_ref_time + i_entry.interval;
        end
    end

endmodule

/* rtl/periodic_task_timer_table.sv */
// Periodic task timer table: top level with control, valid bits and result register.
//
// Task slots live in one memory with a registered read; slot valid bits are flip-flops
// cleared by reset. An add word stores the task in the lowest free slot, if one is free,
// as it is accepted, and its result is presented from the response state. A tick word
// reads the slots one per cycle while no fired result waits on the output, evaluating
// each the cycle after its read and writing it back when it fires. The next word is
// taken once the last result of the current one is in the output register.
module periodic_task_timer_table #(
    parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_cmd,
    input  logic [ptt_pkg::TIME_W-1:0]         i_now_us,
    input  logic [ptt_pkg::TIME_W-1:0]         i_period_us,
    input  logic [ptt_pkg::TIME_W-1:0]         i_start_offset_us,
    input  logic [ptt_pkg::TIME_W-1:0]         i_call_limit,
    input  logic [ptt_pkg::TIME_W-1:0]         i_life_us,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_kind,
    output logic [ptt_pkg::SLOT_W-1:0]         o_task_slot,
    output logic [ptt_pkg::TIME_W-1:0]         o_call_total,
    output logic                               o_retired,
    output logic                               o_last
);
    import ptt_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int ENT_W = $bits(t_entry);

    t_state            r_state, n_state;
    logic [MAX_TASKS-1:0] r_valid;
    logic [CNT_W-1:0]  r_scan;
    logic              r_ev_vld;
    logic [IDX_W-1:0]  r_ev_slot;
    logic [TIME_W-1:0] r_now;
    t_kind             r_resp_kind;
    logic [IDX_W-1:0]  r_resp_slot;
    logic              r_out_vld;
    t_kind             r_out_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic [TIME_W-1:0] r_out_calls;
    logic              r_out_ret;
    logic              r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              ev_go;
    logic              ld_fire;
    logic              ld_resp;
    logic              issue;
    logic              scan_done;
    logic              add_wr;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    t_entry            add_entry;
    logic [ENT_W-1:0]  ram_rdata;
    t_eval_res         ev_res;

    // Handshake helpers
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Slot evaluation on read data
    ptt_eval u_eval (
        .i_slot_valid (r_valid[r_ev_slot]),
        .i_now        (r_now),
        .i_entry      (t_entry'(ram_rdata)),
        .o_res        (ev_res)
    );

    // Scan pipeline control: a fire waits for a free output register
    assign ev_go     = r_ev_vld && (!ev_res.fire || out_free);
    assign ld_fire   = ev_go && ev_res.fire;
    assign issue     = (r_state == S_SCAN) && (r_scan < CNT_W'(MAX_TASKS))
                       && (!r_ev_vld || ev_go);
    assign scan_done = (r_state == S_SCAN) && (r_scan == CNT_W'(MAX_TASKS)) && !r_ev_vld;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd == CMD_ADD) ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        ld_resp    = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_SCAN:  o_in_ready = 1'b0;
            S_RESP:  ld_resp    = out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Memory write: add in idle, write-back of a fired slot in scan
    assign add_wr = in_acc && (i_cmd == CMD_ADD) && free_found;

    always_comb begin
        add_entry.next_ref_time  = i_now_us;
        add_entry.birth_time     = i_now_us;
        add_entry.interval       = i_period_us;
        add_entry.pending_offset = i_start_offset_us;
        add_entry.calls_done     = '0;
        add_entry.calls_allowed  = i_call_limit;
        add_entry.life_span      = i_life_us;
    end

    assign ram_we    = add_wr || ld_fire;
    assign ram_waddr = add_wr ? free_idx : r_ev_slot;
    assign ram_wdata = add_wr ? add_entry : ev_res.entry;

    // Reads and write-backs in a scan always hit different slots
    ptt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_scan    <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (add_wr) begin
                r_valid[free_idx] <= 1'b1;
            end else if (ld_fire && ev_res.done) begin
                r_valid[r_ev_slot] <= 1'b0;
            end
            if (in_acc) begin
                r_scan <= '0;
            end else if (issue) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            if (issue) begin
                r_ev_vld <= 1'b1;
            end else if (ev_go) begin
                r_ev_vld <= 1'b0;
            end
            if (ld_fire || ld_resp) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ev_slot <= r_scan[IDX_W-1:0];
        end
        if (in_acc) begin
            r_now <= i_now_us;
        end
        if (in_acc && (i_cmd == CMD_ADD)) begin
            r_resp_kind <= free_found ? K_ADD_OK : K_ADD_FULL;
            r_resp_slot <= free_found ? free_idx : '0;
        end else if (scan_done) begin
            r_resp_kind <= K_TICK_END;
            r_resp_slot <= '0;
        end
        if (ld_fire) begin
            r_out_kind  <= K_FIRE;
            r_out_slot  <= SLOT_W'(r_ev_slot);
            r_out_calls <= ev_res.calls;
            r_out_ret   <= ev_res.done;
            r_out_last  <= 1'b0;
        end else if (ld_resp) begin
            r_out_kind  <= r_resp_kind;
            r_out_slot  <= SLOT_W'(r_resp_slot);
            r_out_calls <= '0;
            r_out_ret   <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_kind       = r_out_kind;
    assign o_task_slot  = r_out_slot;
    assign o_call_total = r_out_calls;
    assign o_retired    = r_out_ret;
    assign o_last       = r_out_last;

    // Evaluation only happens inside a scan
    a_ev_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == S_SCAN))
        else $error("slot evaluation outside scan");

    // A scan writes memory only for a fired slot
    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_SCAN)) |-> (r_ev_vld && ev_res.fire && out_free))
        else $error("unexpected table write during scan");

    // Fire results never close a word
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == K_FIRE)) |-> !r_out_last)
        else $error("fire result marked last");

    // A retiring fire frees its slot
    a_retire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_fire && ev_res.done) |=> !r_valid[$past(r_ev_slot)])
        else $error("retired slot still valid");

endmodule

/* tb/timer_table_checker.sv */
// Scoreboard for the periodic task timer table: predicts every reply and checks the output.
module timer_table_checker #(
    parameter int SLOTS = ptt_pkg::MAX_TASKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_cmd,
    input  logic [ptt_pkg::TIME_W-1:0] i_now_us,
    input  logic [ptt_pkg::TIME_W-1:0] i_period_us,
    input  logic [ptt_pkg::TIME_W-1:0] i_start_offset_us,
    input  logic [ptt_pkg::TIME_W-1:0] i_call_limit,
    input  logic [ptt_pkg::TIME_W-1:0] i_life_us,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [1:0]                 i_kind,
    input  logic [ptt_pkg::SLOT_W-1:0] i_task_slot,
    input  logic [ptt_pkg::TIME_W-1:0] i_call_total,
    input  logic                       i_retired,
    input  logic                       i_last,
    output int                         o_error_count,
    output int                         o_pending_count,
    output int                         o_fire_count,
    output int                         o_retire_count,
    output int                         o_full_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ptt_pkg::*;

    // Shadow copy of one task slot
    typedef struct packed {
        logic              live;
        logic [TIME_W-1:0] ref_time;
        logic [TIME_W-1:0] born;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] wait_left;
        logic [TIME_W-1:0] calls;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] life;
    } t_task_slot;

    // One reply word as the block should present it
    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] total;
        logic              retired;
        logic              last;
    } t_reply;

    t_task_slot tasks [SLOTS];
    t_reply     expected_replies [$];
    t_reply     want;

    function automatic void queue_reply(t_kind kind, int slot, logic [TIME_W-1:0] total,
                                        logic retired, logic last);
        t_reply r;
        r.kind    = kind;
        r.slot    = SLOT_W'(slot);
        r.total   = total;
        r.retired = retired;
        r.last    = last;
        expected_replies = {expected_replies, r};
    endfunction

    // Apply one input word to the shadow table and queue the replies it causes
    function automatic void run_schedule(logic cmd, logic [TIME_W-1:0] now,
                                         logic [TIME_W-1:0] period,
                                         logic [TIME_W-1:0] offset,
                                         logic [TIME_W-1:0] limit,
                                         logic [TIME_W-1:0] life);
        int s;
        logic placed;
        logic retire;
        logic [TIME_W-1:0] elapsed;
        placed = 1'b0;
        if (cmd == CMD_ADD) begin
            // lowest free slot takes the task
            for (s = 0; s < SLOTS && !placed; s++) begin
                if (!tasks[s].live) begin
                    tasks[s].live      = 1'b1;
                    tasks[s].ref_time  = now;
                    tasks[s].born      = now;
                    tasks[s].step      = period;
                    tasks[s].wait_left = offset;
                    tasks[s].calls     = '0;
                    tasks[s].limit     = limit;
                    tasks[s].life      = life;
                    queue_reply(K_ADD_OK, s, '0, 1'b0, 1'b1);
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                queue_reply(K_ADD_FULL, 0, '0, 1'b0, 1'b1);
                o_full_count++;
            end
        end else begin
            // scan in slot order with one timestamp
            for (s = 0; s < SLOTS; s++) begin
                if (tasks[s].live) begin
                    elapsed = now - tasks[s].ref_time;
                    if (elapsed >= tasks[s].step && elapsed >= tasks[s].wait_left) begin
                        tasks[s].calls = tasks[s].calls + TIME_W'(1);
                        if (tasks[s].wait_left == '0) begin
                            tasks[s].ref_time = tasks[s].ref_time + tasks[s].step;
                        end else begin
                            // first call after the start offset restarts the task
                            tasks[s].wait_left = '0;
                            tasks[s].born      = now;
                            tasks[s].ref_time  = now;
                        end
                        elapsed = now - tasks[s].born;
                        retire = (tasks[s].limit != '0 && tasks[s].calls >= tasks[s].limit) ||
                                 (tasks[s].life != '0 && elapsed >= tasks[s].life);
                        if (retire) begin
                            tasks[s].live = 1'b0;
                            o_retire_count++;
                        end
                        queue_reply(K_FIRE, s, tasks[s].calls, retire, 1'b0);
                        o_fire_count++;
                    end
                end
            end
            queue_reply(K_TICK_END, 0, '0, 1'b0, 1'b1);
        end
    endfunction

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                tasks[s].live = 1'b0;
            end
            expected_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                run_schedule(i_cmd, i_now_us, i_period_us, i_start_offset_us,
                             i_call_limit, i_life_us);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply word with nothing expected: kind %0d slot %0d",
                           i_kind, i_task_slot);
                    o_error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_kind);
                        o_error_count++;
                    end
                    if (i_task_slot !== want.slot) begin
                        $error("task_slot: expected %0d, got %0d", want.slot, i_task_slot);
                        o_error_count++;
                    end
                    if (i_call_total !== want.total) begin
                        $error("call_total: expected %0d, got %0d", want.total, i_call_total);
                        o_error_count++;
                    end
                    if (i_retired !== want.retired) begin
                        $error("retired: expected %0d, got %0d", want.retired, i_retired);
                        o_error_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        o_error_count++;
                    end
                end
            end
        end
        o_pending_count = expected_replies.size();
    end

endmodule

/* tb/periodic_task_timer_table_test.sv */
// Testbench top for the periodic task timer table: clock, reset, stimulus and verdict.
module periodic_task_timer_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ptt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 245;
    localparam int GAP_MAX      = 18;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_WORDS  = 30;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_in_valid        = 1'b0;
    logic              i_cmd             = CMD_ADD;
    logic [TIME_W-1:0] i_now_us          = '0;
    logic [TIME_W-1:0] i_period_us       = '0;
    logic [TIME_W-1:0] i_start_offset_us = '0;
    logic [TIME_W-1:0] i_call_limit      = '0;
    logic [TIME_W-1:0] i_life_us         = '0;
    logic              i_out_ready       = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [1:0]        o_kind;
    logic [SLOT_W-1:0] o_task_slot;
    logic [TIME_W-1:0] o_call_total;
    logic              o_retired;
    logic              o_last;

    int error_count;
    int pending_count;
    int fire_count;
    int retire_count;
    int full_count;
    int cycle_count = 0;
    int in_gap_max  = GAP_MAX;
    int out_gap_max = GAP_MAX;
    int add_count   = 0;
    int tick_count  = 0;

    logic [TIME_W-1:0] clock_us;

    periodic_task_timer_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_now_us          (i_now_us),
        .i_period_us       (i_period_us),
        .i_start_offset_us (i_start_offset_us),
        .i_call_limit      (i_call_limit),
        .i_life_us         (i_life_us),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_task_slot       (o_task_slot),
        .o_call_total      (o_call_total),
        .o_retired         (o_retired),
        .o_last            (o_last)
    );

    timer_table_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_now_us          (i_now_us),
        .i_period_us       (i_period_us),
        .i_start_offset_us (i_start_offset_us),
        .i_call_limit      (i_call_limit),
        .i_life_us         (i_life_us),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_kind            (o_kind),
        .i_task_slot       (o_task_slot),
        .i_call_total      (o_call_total),
        .i_retired         (o_retired),
        .i_last            (o_last),
        .o_error_count     (error_count),
        .o_pending_count   (pending_count),
        .o_fire_count      (fire_count),
        .o_retire_count    (retire_count),
        .o_full_count      (full_count)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: random stall before each reply word
    initial begin
        int hold;
        forever begin
            hold = $urandom_range(0, out_gap_max);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Present one word after a random gap and hold it until taken
    task automatic send_word(input logic cmd, input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] period,
                             input logic [TIME_W-1:0] offset,
                             input logic [TIME_W-1:0] limit,
                             input logic [TIME_W-1:0] life);
        int hold;
        hold = $urandom_range(0, in_gap_max);
        if (hold > 0) begin
            i_in_valid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_cmd             <= cmd;
        i_now_us          <= now;
        i_period_us       <= period;
        i_start_offset_us <= offset;
        i_call_limit      <= limit;
        i_life_us         <= life;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd == CMD_ADD) add_count++;
        else tick_count++;
    endtask

    // Mostly small values, some zero, some across the full 32 bits
    function automatic logic [TIME_W-1:0] draw_field(int zero_pct, int wide_pct, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        if (r < zero_pct + wide_pct) return $urandom;
        return $urandom_range(1, hi);
    endfunction

    initial begin
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] offset;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] life;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty scan, field extremes, wrap, offset restart, lifetime
        send_word(CMD_TICK, '0, '0, '0, '0, '0);
        send_word(CMD_ADD, 32'hFFFF_FFF0, 32'd0, 32'd0, 32'd0, 32'd100);
        send_word(CMD_ADD, 32'hFFFF_FFF0, 32'd10, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_word(CMD_ADD, 32'hFFFF_FFF0, 32'd5, 32'd20, 32'd3, 32'd0);
        send_word(CMD_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                  32'hFFFF_FFFF);
        send_word(CMD_ADD, 32'hFFFF_FFF0, 32'd3, 32'd0, 32'd0, 32'd25);
        send_word(CMD_TICK, 32'h0000_0005, '0, '0, '0, '0);
        send_word(CMD_TICK, 32'hFFFF_FFEF, '0, '0, '0, '0);
        // fill the table; the last add finds no room
        for (int k = 0; k < 15; k++) begin
            send_word(CMD_ADD, 32'h0000_0100, 32'd1, 32'd0, 32'd1, 32'd0);
        end
        // retire the one-shot tasks, then reuse a freed slot
        send_word(CMD_TICK, 32'h0000_0200, '0, '0, '0, '0);
        send_word(CMD_ADD, 32'h0000_0200, 32'd7, 32'd0, 32'd2, 32'd0);

        // Random: mostly forward-moving time, with occasional jumps anywhere
        clock_us = 32'h0000_0200;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_WORDS == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        in_gap_max  = 0;
                        out_gap_max = 0;
                    end
                    1: begin
                        in_gap_max  = GAP_MAX;
                        out_gap_max = 0;
                    end
                    2: begin
                        in_gap_max  = 0;
                        out_gap_max = GAP_MAX;
                    end
                    default: begin
                        in_gap_max  = GAP_MAX;
                        out_gap_max = GAP_MAX;
                    end
                endcase
            end
            if ($urandom_range(0, 99) < 5) clock_us = $urandom;
            else clock_us = clock_us + $urandom_range(0, 40);
            if ($urandom_range(0, 99) < 42) begin
                period = draw_field(10, 8, 40);
                offset = draw_field(60, 5, 60);
                limit  = draw_field(20, 4, 6);
                life   = draw_field(35, 4, 120);
                // keep never-ending tasks rare so slots keep turning over
                if (limit == '0 && life == '0 && $urandom_range(0, 3) != 0) begin
                    limit = $urandom_range(1, 6);
                end
                send_word(CMD_ADD, clock_us, period, offset, limit, life);
            end else begin
                send_word(CMD_TICK, clock_us, $urandom, $urandom, $urandom, $urandom);
            end
        end
        i_in_valid <= 1'b0;

        // Drain and report; one edge lets the checker log the last word first
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Summary: %0d add words and %0d tick words sent", add_count, tick_count);
        $display("Summary: %0d tasks fired, %0d retired, %0d adds refused on a full table",
                 fire_count, retire_count, full_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/ptt_eval.sv
rtl/periodic_task_timer_table.sv
tb/timer_table_checker.sv
tb/periodic_task_timer_table_test.sv
